[hw/rtl/fmn_pkg.sv]
// shared constants for the fraction multiply and normalize block
`timescale 1ns / 1ps

package fmn_pkg;

    // result field widths
    localparam int RES_NUM_W   = 32;
    localparam int RES_DEN_W   = 31;

    // result tdata: res_num then res_den, padded to whole bytes
    localparam int M_TDATA_W   = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

    // width used to extend, negate and truncate the quotients into res_num and res_den
    localparam int EXT_W       = 64;

endpackage

[hw/rtl/fraction_multiply_normalize.sv]
// product of two signed fractions reduced by euclid gcd on a shared divider
//
//  channel   dir  tdata fields (low bit up)                      tuser
//  s_axis    in   a_num, a_den, b_num, b_den (OPERAND_WIDTH ea)   -
//  m_axis    out  res_num[31:0], res_den[30:0], zero pad          zero_den_error
//
//  a request runs two multiplies on one multiplier and a special case
//  check, then euclid remainder steps on the divider, two final quotients
//  (numerator and denominator over the gcd) and a load of the output
//  register, which waits while an earlier result is still not taken.
//  the divider is bit-serial and restoring: one quotient bit a cycle.
//  zero numerator or zero denominator skip the divider.
//  s_tready is high only while idle; a finished result waits in the output
//  register and a new request is taken meanwhile. rst_n clears control state.
`timescale 1ns / 1ps

module fraction_multiply_normalize #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // a_num, a_den, b_num, b_den from the low bit up, zero padded
    input  logic [((4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // res_num, res_den from the low bit up, zero padded
    output logic [fmn_pkg::M_TDATA_W - 1:0]              m_tdata,
    // zero_den_error
    output logic                                         m_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready
);

    localparam int W  = OPERAND_WIDTH;
    localparam int P  = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(P);

    // sequencer codes
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_N    = 4'd1;
    localparam logic [3:0] ST_MUL_D    = 4'd2;
    localparam logic [3:0] ST_CHECK    = 4'd3;
    localparam logic [3:0] ST_GCD_DIV  = 4'd4;
    localparam logic [3:0] ST_GCD_NEXT = 4'd5;
    localparam logic [3:0] ST_QN_DIV   = 4'd6;
    localparam logic [3:0] ST_QD_DIV   = 4'd7;
    localparam logic [3:0] ST_WRITE    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // operand magnitudes and product sign
    logic [W-1:0]  ma_reg, ma_next;
    logic [W-1:0]  mad_reg, mad_next;
    logic [W-1:0]  mb_reg, mb_next;
    logic [W-1:0]  mbd_reg, mbd_next;
    logic          neg_reg, neg_next;

    // products
    logic [P-1:0]  pnum_reg, pnum_next;
    logic [P-1:0]  pden_reg, pden_next;

    // divider state
    logic [P:0]    rem_reg, rem_next;
    logic [P-1:0]  quo_reg, quo_next;
    logic [P-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // reduced parts and error flag
    logic [P-1:0]  qn_reg, qn_next;
    logic [P-1:0]  qd_reg, qd_next;
    logic          err_reg, err_next;

    // output register
    logic [fmn_pkg::RES_NUM_W-1:0] res_num_reg, res_num_next;
    logic [fmn_pkg::RES_DEN_W-1:0] res_den_reg, res_den_next;
    logic                          res_err_reg, res_err_next;

    // input field split
    logic [W-1:0]  f_an, f_ad, f_bn, f_bd;
    logic [W-1:0]  m_an, m_ad, m_bn, m_bd;

    // shared multiplier
    logic [W-1:0]  mul_x, mul_y;
    logic [P-1:0]  mul_p;

    // shared divider step
    logic [P:0]    rem_shift;
    logic          div_fits;
    logic [P:0]    rem_step;
    logic [P-1:0]  quo_step;
    logic          div_last;

    // result sign handling
    logic [fmn_pkg::EXT_W-1:0] qn_ext, qd_ext, qn_signed;

    logic          s_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // fields and their magnitudes at operand width
    assign f_an = s_tdata[W-1:0];
    assign f_ad = s_tdata[2*W-1:W];
    assign f_bn = s_tdata[3*W-1:2*W];
    assign f_bd = s_tdata[4*W-1:3*W];
    assign m_an = f_an[W-1] ? (~f_an + W'(1)) : f_an;
    assign m_ad = f_ad[W-1] ? (~f_ad + W'(1)) : f_ad;
    assign m_bn = f_bn[W-1] ? (~f_bn + W'(1)) : f_bn;
    assign m_bd = f_bd[W-1] ? (~f_bd + W'(1)) : f_bd;

    // one multiplier, numerators first then denominators
    assign mul_x = (state_reg == ST_MUL_N) ? ma_reg : mad_reg;
    assign mul_y = (state_reg == ST_MUL_N) ? mb_reg : mbd_reg;
    assign mul_p = P'(mul_x) * P'(mul_y);

    // restoring divider, one quotient bit a cycle
    assign rem_shift = {rem_reg[P-1:0], quo_reg[P-1]};
    assign div_fits  = (rem_shift >= {1'b0, dvs_reg});
    assign rem_step  = div_fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
    assign quo_step  = {quo_reg[P-2:0], div_fits};
    assign div_last  = (cnt_reg == '0);

    // negate and fit to the result fields
    assign qn_ext    = fmn_pkg::EXT_W'(qn_reg);
    assign qd_ext    = fmn_pkg::EXT_W'(qd_reg);
    assign qn_signed = neg_reg ? (fmn_pkg::EXT_W'(0) - qn_ext) : qn_ext;

    // sequencer and datapath next values
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        ma_next       = ma_reg;
        mad_next      = mad_reg;
        mb_next       = mb_reg;
        mbd_next      = mbd_reg;
        neg_next      = neg_reg;
        pnum_next     = pnum_reg;
        pden_next     = pden_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        qn_next       = qn_reg;
        qd_next       = qd_reg;
        err_next      = err_reg;
        res_num_next  = res_num_reg;
        res_den_next  = res_den_reg;
        res_err_next  = res_err_reg;

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    ma_next    = m_an;
                    mad_next   = m_ad;
                    mb_next    = m_bn;
                    mbd_next   = m_bd;
                    neg_next   = (f_an[W-1] ^ f_bn[W-1]) ^ (f_ad[W-1] ^ f_bd[W-1]);
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N:
            begin
                pnum_next  = mul_p;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                pden_next  = mul_p;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // special cases bypass the divider
                priority if (pden_reg == '0)
                begin
                    qn_next    = '0;
                    qd_next    = '0;
                    err_next   = 1'b1;
                    neg_next   = 1'b0;
                    state_next = ST_WRITE;
                end
                else if (pnum_reg == '0)
                begin
                    qn_next    = '0;
                    qd_next    = P'(1);
                    err_next   = 1'b0;
                    neg_next   = 1'b0;
                    state_next = ST_WRITE;
                end
                else
                begin
                    err_next   = 1'b0;
                    quo_next   = pnum_reg;
                    dvs_next   = pden_reg;
                    rem_next   = '0;
                    cnt_next   = CW'(P - 1);
                    state_next = ST_GCD_DIV;
                end
            end
            ST_GCD_DIV, ST_QN_DIV, ST_QD_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - CW'(1);
                if (div_last)
                begin
                    unique case (state_reg)
                        ST_GCD_DIV:
                        begin
                            state_next = ST_GCD_NEXT;
                        end
                        ST_QN_DIV:
                        begin
                            // next quotient: denominator over the same gcd
                            qn_next    = quo_step;
                            quo_next   = pden_reg;
                            rem_next   = '0;
                            cnt_next   = CW'(P - 1);
                            state_next = ST_QD_DIV;
                        end
                        default:
                        begin
                            qd_next    = quo_step;
                            state_next = ST_WRITE;
                        end
                    endcase
                end
            end
            ST_GCD_NEXT:
            begin
                rem_next = '0;
                cnt_next = CW'(P - 1);
                if (rem_reg[P-1:0] == '0)
                begin
                    // divisor holds the gcd; reduce the numerator
                    quo_next   = pnum_reg;
                    state_next = ST_QN_DIV;
                end
                else
                begin
                    quo_next   = dvs_reg;
                    dvs_next   = rem_reg[P-1:0];
                    state_next = ST_GCD_DIV;
                end
            end
            ST_WRITE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    res_num_next  = qn_signed[fmn_pkg::RES_NUM_W-1:0];
                    res_den_next  = qd_ext[fmn_pkg::RES_DEN_W-1:0];
                    res_err_next  = err_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ma_reg      <= ma_next;
        mad_reg     <= mad_next;
        mb_reg      <= mb_next;
        mbd_reg     <= mbd_next;
        neg_reg     <= neg_next;
        pnum_reg    <= pnum_next;
        pden_reg    <= pden_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        cnt_reg     <= cnt_next;
        qn_reg      <= qn_next;
        qd_reg      <= qd_next;
        err_reg     <= err_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_err_reg <= res_err_next;
    end

    // output channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_err_reg;
    assign m_tdata  = fmn_pkg::M_TDATA_W'({res_den_reg, res_num_reg});

endmodule

[test/fraction_multiply_normalize_test.sv]
// self-checking stream testbench for the reduced fraction product block
`timescale 1ns / 1ps

module fraction_multiply_normalize_test;

    localparam int OPW          = 16;
    localparam int S_TDATA_W    = ((4 * OPW + 7) / 8) * 8;
    localparam int N_RANDOM     = 1400;
    localparam int HOLD_CYCLES  = 3000;
    // worst request: a long remainder chain and two final quotients
    localparam int WORST_REQ    = 1700;
    localparam int MAX_GAP      = 100;
    localparam int DRAIN_CYCLES = 2000;

    // operand fields, a_num in the low bits
    typedef struct packed {
        logic [OPW - 1:0] b_den;
        logic [OPW - 1:0] b_num;
        logic [OPW - 1:0] a_den;
        logic [OPW - 1:0] a_num;
    } operands_t;

    typedef struct packed {
        logic                            err;
        logic [fmn_pkg::RES_DEN_W - 1:0] den;
        logic [fmn_pkg::RES_NUM_W - 1:0] num;
    } product_t;

    typedef enum logic [2:0] {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_SINK_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } traffic_phase_e;

    logic                            clk;
    logic                            rst_n    = 1'b0;
    logic [S_TDATA_W - 1:0]          s_tdata  = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [fmn_pkg::M_TDATA_W - 1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;

    operands_t      pending_operands[$];
    product_t       expected_products[$];
    int             sent_count;
    int             n_directed;
    int             chunk_len;
    int             cycle_limit;
    int             hold_left;
    logic           hold_armed;
    traffic_phase_e traffic_phase;
    int             idle_pct;
    int             stall_pct;

    int             error_count;
    int             results_seen;
    int             zero_den_seen;
    int             zero_num_seen;
    int             negative_seen;

    fraction_multiply_normalize #(
        .OPERAND_WIDTH(OPW)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // magnitude of one operand field
    function automatic logic [63:0] magnitude(input logic [OPW - 1:0] v);
        logic [OPW - 1:0] t;
        t = ~v + 1'b1;
        return v[OPW - 1] ? {{(64 - OPW){1'b0}}, t} : {{(64 - OPW){1'b0}}, v};
    endfunction

    // exact product reduced by its gcd, sign carried on the numerator
    function automatic product_t reduce_product(input operands_t op);
        logic [63:0] pnum;
        logic [63:0] pden;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] qn;
        logic [63:0] signed_qn;
        logic        neg;
        product_t    p;
        pnum = magnitude(op.a_num) * magnitude(op.b_num);
        pden = magnitude(op.a_den) * magnitude(op.b_den);
        p    = '0;
        if (pden == 0)
        begin
            p.err = 1'b1;
        end
        else if (pnum == 0)
        begin
            p.den = 1;
        end
        else
        begin
            neg = (op.a_num[OPW - 1] ^ op.b_num[OPW - 1]) ^
                  (op.a_den[OPW - 1] ^ op.b_den[OPW - 1]);
            x = pnum;
            y = pden;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            qn        = pnum / x;
            signed_qn = neg ? (64'd0 - qn) : qn;
            r         = pden / x;
            p.num     = signed_qn[fmn_pkg::RES_NUM_W - 1:0];
            p.den     = r[fmn_pkg::RES_DEN_W - 1:0];
        end
        return p;
    endfunction

    // magnitude with a random sign
    function automatic logic [OPW - 1:0] signed_pick(input int unsigned mag);
        logic [OPW - 1:0] m;
        m = mag[OPW - 1:0];
        return $urandom_range(1) ? (~m + 1'b1) : m;
    endfunction

    task automatic queue_request(input int an, input int ad, input int bn, input int bd);
        operands_t op;
        op.a_num = an[OPW - 1:0];
        op.a_den = ad[OPW - 1:0];
        op.b_num = bn[OPW - 1:0];
        op.b_den = bd[OPW - 1:0];
        pending_operands.push_back(op);
    endtask

    // traffic shaping follows the number of requests taken
    always_comb
    begin
        if (sent_count < n_directed + chunk_len)
            traffic_phase = PH_STEADY;
        else if (sent_count < n_directed + 2 * chunk_len)
            traffic_phase = PH_SENDER_IDLE;
        else if (sent_count < n_directed + 3 * chunk_len)
            traffic_phase = PH_SINK_STALL;
        else if (sent_count < n_directed + 4 * chunk_len)
            traffic_phase = PH_BOTH_IDLE;
        else
            traffic_phase = PH_BACKPRESSURE;
        case (traffic_phase)
            PH_SENDER_IDLE:
            begin
                idle_pct  = 86;
                stall_pct = 0;
            end
            PH_SINK_STALL:
            begin
                idle_pct  = 0;
                stall_pct = 86;
            end
            PH_BOTH_IDLE:
            begin
                idle_pct  = 19;
                stall_pct = 19;
            end
            default:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
    end

    // request driver: predict on acceptance, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin : driver
        operands_t op;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            sent_count <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                expected_products.push_back(reduce_product(operands_t'(s_tdata)));
                sent_count <= sent_count + 1;
            end
            if (pending_operands.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                op = pending_operands.pop_front();
                s_tdata  <= op;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // one long sink hold once backpressure begins, sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && traffic_phase == PH_BACKPRESSURE)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result sink ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin : monitor
        product_t got;
        product_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.num = m_tdata[fmn_pkg::RES_NUM_W - 1:0];
            got.den = m_tdata[fmn_pkg::RES_NUM_W +: fmn_pkg::RES_DEN_W];
            got.err = m_tuser;
            results_seen++;
            if (expected_products.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result: num %0d den %0d err %0b",
                         $time, $signed(got.num), got.den, got.err);
            end
            else
            begin
                want = expected_products.pop_front();
                if (got.num !== want.num)
                begin
                    error_count++;
                    $display("%0t res_num mismatch: expected %0d actual %0d",
                             $time, $signed(want.num), $signed(got.num));
                end
                if (got.den !== want.den)
                begin
                    error_count++;
                    $display("%0t res_den mismatch: expected %0d actual %0d",
                             $time, want.den, got.den);
                end
                if (got.err !== want.err)
                begin
                    error_count++;
                    $display("%0t zero_den_error mismatch: expected %0b actual %0b",
                             $time, want.err, got.err);
                end
                if (want.err)
                    zero_den_seen++;
                else if (want.num == 0)
                    zero_num_seen++;
                else if (want.num[fmn_pkg::RES_NUM_W - 1])
                    negative_seen++;
            end
        end
    end

    // run watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        wait (cycle_limit != 0);
        while (cycles < cycle_limit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t timeout after %0d cycles, %0d results pending",
                 $time, cycles, expected_products.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        operands_t   op;
        int unsigned pick;
        int unsigned g;
        cycle_limit   = 0;
        error_count   = 0;
        results_seen  = 0;
        zero_den_seen = 0;
        zero_num_seen = 0;
        negative_seen = 0;

        // zero denominators, alone and with zero numerators
        queue_request(3, 4, 2, 0);
        queue_request(3, 0, 2, 5);
        queue_request(0, 0, 0, 0);
        queue_request(0, 5, 7, 0);
        // zero numerators give 0/1 whatever the signs
        queue_request(0, 7, 5, 3);
        queue_request(5, -7, 0, -3);
        // integer times fraction
        queue_request(6, 1, 5, 10);
        queue_request(-4, 1, 3, -8);
        // most negative operand at its exact magnitude
        queue_request(-32768, -32768, -32768, -32768);
        queue_request(-32768, 1, -32768, 1);
        queue_request(1, -32768, 1, -32768);
        queue_request(-32768, 1, 32767, 1);
        queue_request(32767, -32768, 32767, 32767);
        queue_request(32767, 32767, 32767, 32767);
        // no negative, each single negative and all four negative
        queue_request(3, 5, 7, 11);
        queue_request(-3, 5, 7, 11);
        queue_request(3, -5, 7, 11);
        queue_request(3, 5, -7, 11);
        queue_request(3, 5, 7, -11);
        queue_request(-3, -5, -7, -11);
        queue_request(-1, 1, 1, 1);
        // consecutive fibonacci terms make the longest remainder chains
        queue_request(28657, 1, 1, 17711);
        queue_request(-17711, 10946, 28657, -1);
        queue_request(-1, -1, -1, -1);
        n_directed = pending_operands.size();

        // random requests: full range, small, shared factors, integer, special
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(99);
            op   = {$urandom, $urandom};
            if (pick >= 45 && pick < 70)
            begin
                op = {signed_pick($urandom_range(512)), signed_pick($urandom_range(512)),
                      signed_pick($urandom_range(512)), signed_pick($urandom_range(512))};
            end
            else if (pick >= 70 && pick < 85)
            begin
                g  = $urandom_range(2, 181);
                op = {signed_pick(g * $urandom_range(1, 32767 / g)),
                      signed_pick(g * $urandom_range(1, 32767 / g)),
                      signed_pick(g * $urandom_range(1, 32767 / g)),
                      signed_pick(g * $urandom_range(1, 32767 / g))};
            end
            else if (pick >= 85 && pick < 90)
            begin
                op.a_den = 1;
            end
            else if (pick >= 90 && pick < 95)
            begin
                g = $urandom_range(2);
                if (g != 1)
                    op.a_den = '0;
                if (g != 0)
                    op.b_den = '0;
            end
            else if (pick >= 95)
            begin
                g = $urandom_range(2);
                if (g != 1)
                    op.a_num = '0;
                if (g != 0)
                    op.b_num = '0;
            end
            pending_operands.push_back(op);
        end
        chunk_len   = N_RANDOM / 5;
        cycle_limit = 4 * ((n_directed + N_RANDOM) * (WORST_REQ + MAX_GAP) + HOLD_CYCLES)
                      + DRAIN_CYCLES;

        // single reset at the start
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_operands.size() != 0 || s_tvalid || expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_products.size() != 0)
        begin
            error_count++;
            $display("%0t %0d expected results never arrived", $time, expected_products.size());
        end
        $display("tb: %0d requests checked: %0d zero-denominator flags,", results_seen,
                 zero_den_seen);
        $display("tb: %0d zero products, %0d negative; traffic ran steady, sender idle,",
                 zero_num_seen, negative_seen);
        $display("tb: sink stall, both idle and a %0d-cycle sink hold", HOLD_CYCLES);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[fraction_multiply_normalize.f]
hw/rtl/fmn_pkg.sv
hw/rtl/fraction_multiply_normalize.sv
test/fraction_multiply_normalize_test.sv
